// ===== rtl/csvfs_pkg.sv =====
// shared types and constants of the csv field splitter
package csvfs_pkg;

	localparam logic [7:0] QUOTE_CHAR  = 8'h22;
	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam int         NUM_RES     = 3;

	typedef enum logic [2:0] {
		KIND_CONTENT    = 3'd0,
		KIND_FIELD_END  = 3'd1,
		KIND_ROW_OK     = 3'd2,
		KIND_MISMATCH   = 3'd3,
		KIND_HEADER_END = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       line_last;
		logic       file_start;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] quote_run;
		logic        in_header;
		logic [8:0]  column;
		logic [15:0] row;
		logic        last;
	} result_t;

endpackage

// ===== rtl/csvfs_if.sv =====
// handshake channels of the csv field splitter

interface csvfs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       line_last;
	logic       file_start;

	modport source (output valid, output text_byte, output line_last, output file_start,
		input ready);
	modport sink (input valid, input text_byte, input line_last, input file_start,
		output ready);
endinterface

interface csvfs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic [15:0] quote_run;
	logic        in_header;
	logic [8:0]  column;
	logic [15:0] row;
	logic        last;

	modport source (output valid, output kind, output out_byte, output quote_run,
		output in_header, output column, output row, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input quote_run,
		input in_header, input column, input row, input last, output ready);
endinterface

interface csvfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] delimiter;

	modport source (output valid, output delimiter, input ready);
	modport sink (input valid, input delimiter, output ready);
endinterface

// ===== rtl/csv_field_splitter_unit.sv =====
// csv field splitter top level: input register, parser, result bundle
// a byte is held in the input register, then its results in the result bundle
// throughput: one byte per cycle while each byte yields at most one result
// and the result port takes one per cycle; a byte yielding k results holds
// the input register for k output transfers of the 3-entry result bundle
// reset: parser in header phase with empty counts, delimiter set to comma
module csv_field_splitter_unit #(
	parameter int MAX_COLUMNS = 256
) (
	input logic         clk,
	input logic         arst_n,
	csvfs_in_if.sink    text,
	csvfs_out_if.source result,
	csvfs_cfg_if.sink   cfg
);
	import csvfs_pkg::*;

	logic       v_s1;
	item_t      item_s1;
	logic [7:0] delim_q;
	result_t    ent_q [NUM_RES];
	logic [1:0] cnt_q;

	result_t    res [NUM_RES];
	logic [1:0] nres;
	logic       adv, in_xfer, out_xfer;

	assign out_xfer  = result.valid && result.ready;
	assign adv       = v_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_xfer));
	assign text.ready = !v_s1 || adv;
	assign in_xfer   = text.valid && text.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg.valid) begin
			delim_q <= cfg.delimiter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.text_byte  <= text.text_byte;
			item_s1.line_last  <= text.line_last;
			item_s1.file_start <= text.file_start;
		end
	end

	csvfs_core #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.item      (item_s1),
		.delimiter (delim_q),
		.res       (res),
		.nres      (nres)
	);

	// result bundle: entry 0 is on the port, shifts down on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv) begin
			cnt_q <= nres;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_q <= res;
		end else if (out_xfer) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	assign result.valid     = (cnt_q != 2'd0);
	assign result.kind      = ent_q[0].kind;
	assign result.out_byte  = ent_q[0].out_byte;
	assign result.quote_run = ent_q[0].quote_run;
	assign result.in_header = ent_q[0].in_header;
	assign result.column    = ent_q[0].column;
	assign result.row       = ent_q[0].row;
	assign result.last      = ent_q[0].last;

`ifndef ASSERT_OFF
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> ent_q[0].last)
		else $error("final bundled result lacks last");

	a_no_early_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q > 2'd1 |-> !ent_q[0].last)
		else $error("last set before the final result");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(item_s1))
		else $error("input register lost a pending byte");

	a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> v_s1)
		else $error("transferred byte not held in input register");
`endif

endmodule

// ===== rtl/csvfs_core.sv =====
// parser state and per-byte result generation
module csvfs_core #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  csvfs_pkg::item_t  item,
	input  logic [7:0]        delimiter,
	output csvfs_pkg::result_t res [csvfs_pkg::NUM_RES],
	output logic [1:0]        nres
);
	import csvfs_pkg::*;

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLUMNS);

	logic             hdr_q, quoted_q, fstart_q, err_q, pdelim_q;
	logic [15:0]      pq_q, row_q;
	logic [CNT_W-1:0] fc_q, hcols_q;

	logic             hdr_d, quoted_d, fstart_d, err_d, pdelim_d;
	logic [15:0]      pq_d, row_d;
	logic [CNT_W-1:0] fc_d, hcols_d;

	function automatic result_t mk_res(kind_t k, logic [7:0] b, logic [15:0] q, logic h,
		logic [CNT_W-1:0] c, logic [15:0] r);
		result_t x;
		x.kind      = k;
		x.out_byte  = b;
		x.quote_run = q;
		x.in_header = h;
		x.column    = 9'(c);
		x.row       = r;
		x.last      = 1'b0;
		return x;
	endfunction

	always_comb begin
		hdr_d    = hdr_q;
		quoted_d = quoted_q;
		fstart_d = fstart_q;
		err_d    = err_q;
		pdelim_d = pdelim_q;
		pq_d     = pq_q;
		row_d    = row_q;
		fc_d     = fc_q;
		hcols_d  = hcols_q;
		nres     = 2'd0;
		for (int i = 0; i < NUM_RES; i++) begin
			res[i] = '0;
		end

		if (item.file_start) begin
			hdr_d    = 1'b1;
			hcols_d  = '0;
			row_d    = '0;
			err_d    = 1'b0;
			quoted_d = 1'b0;
			fstart_d = 1'b1;
			pq_d     = '0;
			fc_d     = '0;
			pdelim_d = 1'b0;
		end

		if (!err_d) begin
			if (hdr_d) begin
				if (item.text_byte == delimiter) begin
					res[nres] = mk_res(KIND_FIELD_END, 8'd0, 16'd0, 1'b1, fc_d, 16'd0);
					nres = nres + 2'd1;
					if (fc_d < CNT_MAX) fc_d = fc_d + 1'b1;
					pdelim_d = 1'b1;
				end else begin
					res[nres] = mk_res(KIND_CONTENT, item.text_byte, 16'd0, 1'b1, fc_d, 16'd0);
					nres = nres + 2'd1;
					pdelim_d = 1'b0;
				end
				if (item.line_last) begin
					if (!pdelim_d) begin
						res[nres] = mk_res(KIND_FIELD_END, 8'd0, 16'd0, 1'b1, fc_d, 16'd0);
						nres = nres + 2'd1;
						if (fc_d < CNT_MAX) fc_d = fc_d + 1'b1;
					end
					hcols_d = fc_d;
					res[nres] = mk_res(KIND_HEADER_END, 8'd0, 16'd0, 1'b1, hcols_d, 16'd0);
					nres = nres + 2'd1;
					hdr_d    = 1'b0;
					quoted_d = 1'b0;
					fstart_d = 1'b1;
					pq_d     = '0;
					fc_d     = '0;
					pdelim_d = 1'b0;
				end
			end else begin
				// quote test wins over the delimiter on data lines
				if (item.text_byte == QUOTE_CHAR) begin
					quoted_d = ~quoted_d;
					if (!fstart_d && pq_d != 16'hFFFF) pq_d = pq_d + 16'd1;
				end else if (item.text_byte == delimiter && !quoted_d) begin
					res[nres] = mk_res(KIND_FIELD_END, 8'd0, 16'd0, 1'b0, fc_d, row_d);
					nres = nres + 2'd1;
					if (fc_d < CNT_MAX) fc_d = fc_d + 1'b1;
					pq_d     = '0;
					fstart_d = 1'b1;
				end else begin
					res[nres] = mk_res(KIND_CONTENT, item.text_byte, pq_d, 1'b0, fc_d, row_d);
					nres = nres + 2'd1;
					pq_d     = '0;
					fstart_d = 1'b0;
				end
				if (item.line_last) begin
					res[nres] = mk_res(KIND_FIELD_END, 8'd0, 16'd0, 1'b0, fc_d, row_d);
					nres = nres + 2'd1;
					if (fc_d < CNT_MAX) fc_d = fc_d + 1'b1;
					if (fc_d == hcols_d) begin
						res[nres] = mk_res(KIND_ROW_OK, 8'd0, 16'd0, 1'b0, fc_d, row_d);
						nres = nres + 2'd1;
						if (row_d != 16'hFFFF) row_d = row_d + 16'd1;
					end else begin
						res[nres] = mk_res(KIND_MISMATCH, 8'd0, 16'd0, 1'b0, fc_d, row_d);
						nres = nres + 2'd1;
						err_d = 1'b1;
					end
					quoted_d = 1'b0;
					fstart_d = 1'b1;
					pq_d     = '0;
					fc_d     = '0;
					pdelim_d = 1'b0;
				end
			end
		end

		if (nres != 2'd0) begin
			res[nres - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= 1'b1;
			quoted_q <= 1'b0;
			fstart_q <= 1'b1;
			err_q    <= 1'b0;
			pdelim_q <= 1'b0;
			pq_q     <= '0;
			row_q    <= '0;
			fc_q     <= '0;
			hcols_q  <= '0;
		end else if (fire) begin
			hdr_q    <= hdr_d;
			quoted_q <= quoted_d;
			fstart_q <= fstart_d;
			err_q    <= err_d;
			pdelim_q <= pdelim_d;
			pq_q     <= pq_d;
			row_q    <= row_d;
			fc_q     <= fc_d;
			hcols_q  <= hcols_d;
		end
	end

endmodule
